@@ sv/stcw_pkg.sv @@
// Shared types and constants for the sample-to-chunk table walker.
// No dependencies; stcw_count and the top level import this package.
package stcw_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // The last run extends to chunk 0xFFFFFFFE, so its exclusive bound is all ones.
   localparam logic [31:0] LAST_RUN_BOUND = 32'hFFFF_FFFF;

   // Request modes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_LOAD    = 2'd0;
   localparam mode_type MODE_ADV_SMP = 2'd1;
   localparam mode_type MODE_ADV_CHK = 2'd2;
   localparam mode_type MODE_COUNT   = 2'd3;

   // One run entry as stored in the table memory
   typedef struct packed {
      logic [31:0] base_chunk;
      logic [31:0] chunk_samples;
   } run_entry_type;

   // One run handed to the range accumulator
   typedef struct packed {
      logic        valid;
      logic [31:0] base_chunk;
      logic [31:0] chunk_samples;
      logic [31:0] bound;
   } count_term_type;

endpackage

@@ sv/stcw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stcw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/stcw_count.sv @@
// Range accumulator: sums samples of one run per cycle over an inclusive chunk range.
// Three stages: clip the run to the range, multiply, accumulate. Uses stcw_pkg.
module stcw_count (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  stcw_pkg::count_term_type term,
   input  logic [31:0]             range_start,
   input  logic [31:0]             range_end,
   output logic [31:0]             total
);
   import stcw_pkg::*;

   logic        halt_ff, halt_in;
   logic        s1_take_ff, s1_take_in;
   logic [31:0] s1_cnt_ff, s1_spc_ff;
   logic        s2_take_ff;
   logic [31:0] s2_prod_ff, prod_lo;
   logic [31:0] total_ff;
   logic [31:0] last, hi, lo;

   // Stage 1: clip the run [first, bound-1] against the range
   always_comb begin
      last       = term.bound - 32'd1;
      hi         = (range_end < last) ? range_end : last;
      lo         = (range_start > term.base_chunk) ? range_start : term.base_chunk;
      s1_take_in = term.valid && !halt_ff && (last >= range_start);
      halt_in    = halt_ff | (s1_take_in && (last >= range_end));
   end

   // Stage 2 product, wrapping at 32 bits
   assign prod_lo = s1_cnt_ff * s1_spc_ff;

   // Control: the walk stops after the run that covers the range end
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         halt_ff    <= 1'b0;
         s1_take_ff <= 1'b0;
         s2_take_ff <= 1'b0;
         total_ff   <= '0;
      end else begin
         halt_ff    <= halt_in;
         s1_take_ff <= s1_take_in;
         s2_take_ff <= s1_take_ff;
         if (s2_take_ff) begin
            total_ff <= total_ff + s2_prod_ff;
         end
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      s1_cnt_ff  <= hi - lo + 32'd1;
      s1_spc_ff  <= term.chunk_samples;
      s2_prod_ff <= prod_lo;
   end

   assign total = total_ff;

endmodule

@@ sv/sample_to_chunk_table_walker.sv @@
// Sample-to-chunk table walker, top level.
// Holds a table of run entries (first chunk, samples per chunk) in a RAM and an
// iterator (run, chunk, sample). One request in, one response out, both with
// valid/ready. Request modes: load entry (restart clears the table first),
// advance one sample, advance one chunk, count samples over a chunk range.
// An advance sample that fills its chunk also steps to the next chunk; either
// advance leaves the iterator unchanged on an empty table. The count walk reads
// one table entry per cycle through the single RAM read port.
// One request is worked at a time; req_ready is high only while the walker is
// idle. The response sits in an output register, so a new request is taken
// while the previous response waits; if the receiver still stalls when the next
// result is ready, the walker holds in its final state until rsp_ready.
// Reset empties the table (count to zero) and zeroes the iterator; table
// contents are not cleared, since data read from unloaded entries is never used.
// Uses stcw_pkg, stcw_ram and stcw_count.
module sample_to_chunk_table_walker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  stcw_pkg::mode_type  req_mode,
   input  logic                req_restart,
   input  logic [31:0]         req_entry_first_chunk,
   input  logic [31:0]         req_entry_samples_per_chunk,
   input  logic [31:0]         req_range_start_chunk,
   input  logic [31:0]         req_range_end_chunk,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_position_chunk,
   output logic [31:0]         rsp_position_sample,
   output logic                rsp_position_valid,
   output logic [31:0]         rsp_sample_total,
   output logic                rsp_table_full_error
);
   import stcw_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LOAD    = 4'd1;
   localparam logic [3:0] S_SMP_RD  = 4'd2;
   localparam logic [3:0] S_SMP     = 4'd3;
   localparam logic [3:0] S_CHK_RD  = 4'd4;
   localparam logic [3:0] S_STEP    = 4'd5;
   localparam logic [3:0] S_CNT     = 4'd6;
   localparam logic [3:0] S_DRAIN   = 4'd7;
   localparam logic [3:0] S_FIN_RD  = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;

   logic [3:0]       state_ff, state_in;

   // Latched request
   mode_type         mode_ff;
   logic             restart_ff;
   logic [31:0]      efc_ff, espc_ff, start_ff, end_ff;

   // Iterator and table fill
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [IDX_W-1:0] run_pos_ff, run_pos_in;
   logic [31:0]      chunk_ff, chunk_in;
   logic [31:0]      sample_ff, sample_in;
   logic             err_ff, err_in;

   // Count walk
   logic [CNT_W-1:0] walk_idx_ff, walk_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             prev_ok_ff, prev_ok_in;
   run_entry_type    prev_ff, prev_in;
   logic             drain_ff, drain_in;
   logic             cnt_clear;
   count_term_type   term;
   logic [31:0]      cnt_total;

   // RAM ports
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   run_entry_type    ram_wr_data, ram_rd_data;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in, rsp_load, pos_valid;
   logic [31:0]      rsp_chunk_ff, rsp_sample_ff, rsp_total_ff;
   logic             rsp_pos_valid_ff, rsp_err_ff;

   logic [CNT_W-1:0] base_count, nxt;
   logic [31:0]      sample_inc, chunk_inc;
   logic             req_xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   stcw_ram #(
      .WIDTH ($bits(run_entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   stcw_count u_count (
      .clock       (clock),
      .reset       (reset),
      .clear       (cnt_clear),
      .term        (term),
      .range_start (start_ff),
      .range_end   (end_ff),
      .total       (cnt_total)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      run_pos_in     = run_pos_ff;
      chunk_in       = chunk_ff;
      sample_in      = sample_ff;
      err_in         = err_ff;
      walk_idx_in    = walk_idx_ff;
      rd_pend_in     = 1'b0;
      prev_ok_in     = prev_ok_ff;
      prev_in        = prev_ff;
      drain_in       = drain_ff;
      cnt_clear      = 1'b0;
      term           = '0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = '{base_chunk: efc_ff, chunk_samples: espc_ff};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = run_pos_ff;
      rsp_load       = 1'b0;
      pos_valid      = (entry_count_ff != '0) && (sample_ff < ram_rd_data.chunk_samples);
      base_count     = restart_ff ? '0 : entry_count_ff;
      nxt            = CNT_W'(run_pos_ff) + CNT_W'(1);
      sample_inc     = sample_ff + 32'd1;
      chunk_inc      = chunk_ff + 32'd1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in = 1'b0;
               unique case (req_mode)
                  MODE_LOAD:    state_in = S_LOAD;
                  MODE_ADV_SMP: state_in = S_SMP_RD;
                  MODE_ADV_CHK: state_in = S_CHK_RD;
                  MODE_COUNT: begin
                     state_in    = S_CNT;
                     cnt_clear   = 1'b1;
                     walk_idx_in = '0;
                     prev_ok_in  = 1'b0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // Append an entry; restart empties the table first
         S_LOAD: begin
            if (restart_ff) begin
               entry_count_in = '0;
               run_pos_in     = '0;
               sample_in      = '0;
            end
            if (base_count >= CNT_W'(TABLE_DEPTH)) begin
               err_in = 1'b1;
            end else begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = base_count[IDX_W-1:0];
               entry_count_in = base_count + CNT_W'(1);
               if (base_count == '0) begin
                  run_pos_in = '0;
                  chunk_in   = efc_ff;
                  sample_in  = '0;
               end
            end
            state_in = S_FIN_RD;
         end

         // Advance sample: fetch the current run first
         S_SMP_RD: begin
            if (entry_count_ff == '0) begin
               state_in = S_FIN_RD;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = run_pos_ff;
               state_in    = S_SMP;
            end
         end

         S_SMP: begin
            if (sample_inc >= ram_rd_data.chunk_samples) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = nxt[IDX_W-1:0];
               state_in    = S_STEP;
            end else begin
               sample_in = sample_inc;
               state_in  = S_FIN_RD;
            end
         end

         // Advance chunk: fetch the next run's first chunk
         S_CHK_RD: begin
            if (entry_count_ff == '0) begin
               state_in = S_FIN_RD;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = nxt[IDX_W-1:0];
               state_in    = S_STEP;
            end
         end

         S_STEP: begin
            chunk_in  = chunk_inc;
            sample_in = '0;
            if ((nxt < entry_count_ff) && (chunk_inc >= ram_rd_data.base_chunk)) begin
               run_pos_in = nxt[IDX_W-1:0];
            end
            state_in = S_FIN_RD;
         end

         // Count walk: each run is paired with the next run's first chunk
         S_CNT: begin
            if (walk_idx_ff < entry_count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = walk_idx_ff[IDX_W-1:0];
               walk_idx_in = walk_idx_ff + CNT_W'(1);
               rd_pend_in  = 1'b1;
            end
            if (rd_pend_ff) begin
               term = '{valid: prev_ok_ff, base_chunk: prev_ff.base_chunk,
                        chunk_samples: prev_ff.chunk_samples,
                        bound: ram_rd_data.base_chunk};
               prev_in    = ram_rd_data;
               prev_ok_in = 1'b1;
            end else if (walk_idx_ff >= entry_count_ff) begin
               term = '{valid: prev_ok_ff, base_chunk: prev_ff.base_chunk,
                        chunk_samples: prev_ff.chunk_samples,
                        bound: LAST_RUN_BOUND};
               prev_ok_in = 1'b0;
               drain_in   = 1'b0;
               state_in   = S_DRAIN;
            end
         end

         // Let the accumulator pipeline settle
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_FIN_RD;
            end
         end

         // Fetch the current run for the position valid flag
         S_FIN_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = run_pos_ff;
            state_in    = S_FIN;
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         run_pos_ff     <= '0;
         chunk_ff       <= '0;
         sample_ff      <= '0;
         err_ff         <= 1'b0;
         walk_idx_ff    <= '0;
         rd_pend_ff     <= 1'b0;
         prev_ok_ff     <= 1'b0;
         drain_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         run_pos_ff     <= run_pos_in;
         chunk_ff       <= chunk_in;
         sample_ff      <= sample_in;
         err_ff         <= err_in;
         walk_idx_ff    <= walk_idx_in;
         rd_pend_ff     <= rd_pend_in;
         prev_ok_ff     <= prev_ok_in;
         drain_ff       <= drain_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers: request latch, held run, response
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff    <= req_mode;
         restart_ff <= req_restart;
         efc_ff     <= req_entry_first_chunk;
         espc_ff    <= req_entry_samples_per_chunk;
         start_ff   <= req_range_start_chunk;
         end_ff     <= req_range_end_chunk;
      end
      prev_ff <= prev_in;
      if (rsp_load) begin
         rsp_chunk_ff     <= chunk_ff;
         rsp_sample_ff    <= sample_ff;
         rsp_pos_valid_ff <= pos_valid;
         rsp_total_ff     <= (mode_ff == MODE_COUNT) ? cnt_total : 32'd0;
         rsp_err_ff       <= err_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position_chunk   = rsp_chunk_ff;
   assign rsp_position_sample  = rsp_sample_ff;
   assign rsp_position_valid   = rsp_pos_valid_ff;
   assign rsp_sample_total     = rsp_total_ff;
   assign rsp_table_full_error = rsp_err_ff;

   // The fill count never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // The iterator always points at a loaded run, or at run 0 when empty
   a_run_in_table: assert property (@(posedge clock) disable iff (reset)
      (entry_count_ff == '0) ? (run_pos_ff == '0) : (CNT_W'(run_pos_ff) < entry_count_ff))
      else $error("run position outside loaded table");

   // An accepted request always leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != S_IDLE))
      else $error("request transfer did not start work");

   // Table writes only happen while loading
   a_write_on_load: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_LOAD) && (mode_ff == MODE_LOAD))
      else $error("table write outside a load");

endmodule
